// ===== rtl/top_k_min_heap_sum_defines.svh =====
// Assertion macros for the top_k_min_heap_sum block.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef TOP_K_MIN_HEAP_SUM_DEFINES_SVH
`define TOP_K_MIN_HEAP_SUM_DEFINES_SVH

// Property checked at every rising edge of aclk outside reset.
`define TKH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Property on the cycle after a condition.
`define TKH_ASSERT_NEXT(label, cond, prop, msg) \
    `TKH_ASSERT(label, (cond) |=> (prop), msg)

`endif

// ===== rtl/tkh_pkg.sv =====
// Shared constants, types and helper functions for the top-k retention block.
// No dependencies; every module file imports this package.
package tkh_pkg;

    localparam int CAPACITY = 1024;
    localparam int VAL_W    = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEEP_W   = 11;
    localparam int LIM_W    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
    localparam int ADDR_W   = 2;
    localparam int DATA_W   = 32;

    localparam logic             OP_INSERT       = 1'b0;
    localparam logic             OP_QUERY        = 1'b1;
    localparam logic [ADDR_W-1:0] ADDR_KEEP_COUNT = 2'd0;

    typedef struct packed {
        logic             fill;
        logic             replace;
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] value;
    } cell_ctrl_t;

    // Limit in use: keep_count saturated to 1..CAPACITY.
    function automatic logic [CNT_W-1:0] limit_of(input logic [KEEP_W-1:0] keep);
        logic [LIM_W-1:0] k;
        k = LIM_W'(keep);
        if (k == '0) begin
            k = LIM_W'(1);
        end else if (k > LIM_W'(CAPACITY)) begin
            k = LIM_W'(CAPACITY);
        end
        return k[CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/tkh_apb.sv =====
// Configuration register file with an APB-style slave port.
// Depends on tkh_pkg for widths and the register address.
module tkh_apb import tkh_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [KEEP_W-1:0] keep_count
);

    logic [KEEP_W-1:0] keep_count_reg;
    logic [KEEP_W-1:0] keep_count_next;

    assign pready     = 1'b1;
    assign keep_count = keep_count_reg;

    always_comb begin
        keep_count_next = keep_count_reg;
        if (psel && penable && pwrite && paddr == ADDR_KEEP_COUNT) begin
            keep_count_next = pwdata[KEEP_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_KEEP_COUNT: prdata = DATA_W'(keep_count_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_count_reg <= KEEP_W'(1);
        end else begin
            keep_count_reg <= keep_count_next;
        end
    end

endmodule

// ===== rtl/tkh_cell.sv =====
// One slot of the sorted retention row; holds one value and shifts with its neighbors.
// Depends on tkh_pkg for the value width and the row control struct.
module tkh_cell import tkh_pkg::*; (
    input  logic             aclk,
    input  cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] cell_index,
    input  logic             left_le,
    input  logic [VAL_W-1:0] left_val,
    input  logic             right_lt,
    input  logic [VAL_W-1:0] right_val,
    output logic [VAL_W-1:0] val,
    output logic             le,
    output logic             lt
);

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;
    logic             occupied;

    assign occupied = cell_index < ctrl.count;
    assign le       = occupied && (val_reg <= ctrl.value);
    assign lt       = occupied && (val_reg < ctrl.value);
    assign val      = val_reg;

    // Fill opens a gap at the insertion point and shifts larger values right.
    // Replace drops the head and shifts smaller values left toward it.
    always_comb begin
        val_next = val_reg;
        if (ctrl.fill && (occupied || cell_index == ctrl.count)) begin
            if (le) begin
                val_next = val_reg;
            end else if (left_le) begin
                val_next = ctrl.value;
            end else begin
                val_next = left_val;
            end
        end else if (ctrl.replace && occupied) begin
            if (right_lt) begin
                val_next = right_val;
            end else if (lt) begin
                val_next = ctrl.value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

// ===== rtl/top_k_min_heap_sum.sv =====
// Top-k retention block: keeps the largest keep_count 64-bit values seen and answers sum
// queries. Values sit in a row of CAPACITY cells kept in ascending order, so the head cell
// holds the minimum. On an insert every cell in the row compares the value with its own
// and shifts in step with its neighbors, so one item is accepted per cycle when the result
// side keeps up. A query passes the input register, then its sum is registered into
// m_total_reg. The retained sum is kept as a running total. No clearing pass is needed
// after reset. Depends on tkh_pkg, tkh_apb, tkh_cell and top_k_min_heap_sum_defines.svh.
`include "top_k_min_heap_sum_defines.svh"
module top_k_min_heap_sum import tkh_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_opcode,
    input  logic [VAL_W-1:0]         s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [VAL_W-1:0]  m_total
);

    logic [KEEP_W-1:0] keep_count;
    logic [CNT_W-1:0]  limit;

    logic              in_valid_reg;
    logic              in_op_reg;
    logic [VAL_W-1:0]  in_value_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [VAL_W-1:0]  sum_reg;
    logic [VAL_W-1:0]  sum_next;
    logic              m_valid_reg;
    logic [VAL_W-1:0]  m_total_reg;

    logic              advance;
    logic              do_query;
    logic              fill;
    logic              replace;
    cell_ctrl_t        ctrl;

    logic [VAL_W-1:0]  cell_val [CAPACITY];
    logic              cell_le  [CAPACITY];
    logic              cell_lt  [CAPACITY];

    tkh_apb u_apb (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .keep_count (keep_count)
    );

    assign limit    = limit_of(keep_count);
    assign advance  = in_valid_reg && (in_op_reg == OP_INSERT || !m_valid_reg || m_ready);
    assign do_query = advance && in_op_reg == OP_QUERY;
    assign fill     = advance && in_op_reg == OP_INSERT && count_reg < limit;
    assign replace  = advance && in_op_reg == OP_INSERT && count_reg >= limit && cell_lt[0];
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = m_valid_reg;
    assign m_total  = m_total_reg;

    assign ctrl.fill    = fill;
    assign ctrl.replace = replace;
    assign ctrl.count   = count_reg;
    assign ctrl.value   = in_value_reg;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_row
        logic             left_le;
        logic [VAL_W-1:0] left_val;
        logic             right_lt;
        logic [VAL_W-1:0] right_val;

        if (i == 0) begin : g_head
            assign left_le  = 1'b1;
            assign left_val = '0;
        end else begin : g_body
            assign left_le  = cell_le[i-1];
            assign left_val = cell_val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_lt  = 1'b0;
            assign right_val = '0;
        end else begin : g_inner
            assign right_lt  = cell_lt[i+1];
            assign right_val = cell_val[i+1];
        end

        tkh_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_index (CNT_W'(i)),
            .left_le    (left_le),
            .left_val   (left_val),
            .right_lt   (right_lt),
            .right_val  (right_val),
            .val        (cell_val[i]),
            .le         (cell_le[i]),
            .lt         (cell_lt[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (fill) begin
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + in_value_reg;
        end else if (replace) begin
            sum_next = sum_reg + (in_value_reg - cell_val[0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            count_reg <= count_next;
            sum_reg   <= sum_next;
            if (do_query) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg    <= s_opcode;
            in_value_reg <= s_value;
        end
        if (do_query) begin
            m_total_reg <= sum_reg;
        end
    end

    `TKH_ASSERT(a_head_is_min, count_reg >= CNT_W'(2) |-> cell_val[0] <= cell_val[1], "not sorted")
    `TKH_ASSERT_NEXT(a_fill_count, fill, count_reg == $past(count_reg) + CNT_W'(1), "fill count")
    `TKH_ASSERT_NEXT(a_replace_count, replace, $stable(count_reg), "replace changed the count")
    `TKH_ASSERT_NEXT(a_query_valid, do_query, m_valid_reg, "query gave no result")
    `TKH_ASSERT_NEXT(a_query_total, do_query, m_total_reg == $past(sum_reg), "wrong query total")

endmodule
